// ----- sv/acs_pkg.sv -----
// Package for the rectangle pair collision scanner.
// Holds table sizes, function codes, the stored rectangle entry and the filter lookup.
// No dependencies.
package acs_pkg;

    localparam int SLOTS  = 8;
    localparam int TYPES  = 12;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int FILT_REGS   = 3;
    localparam int FILT_W      = 48;
    localparam int ROW_W       = 12;
    localparam int ROWS_PER_REG = 4;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_SCAN   = 2'd2;

    localparam logic [1:0] REG_FILT_LOW  = 2'd0;
    localparam logic [1:0] REG_FILT_MID  = 2'd1;
    localparam logic [1:0] REG_FILT_HIGH = 2'd2;

    typedef logic [FILT_REGS-1:0][FILT_W-1:0] filt_t;

    // One table entry: geometry plus the attributes read during a scan
    typedef struct packed {
        logic               recv;
        logic [3:0]         kind;
        logic [14:0]        h;
        logic [14:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } rect_t;

    // Bit o of row t: type t is notified when it touches type o
    function automatic logic filter_bit(filt_t flt, logic [3:0] t, logic [3:0] o);
        logic [5:0] pos;
        logic [1:0] sel;
        logic       bit_val;
        pos     = 6'(t[1:0]) * 6'(ROW_W) + 6'(o);
        sel     = t[3:2];
        bit_val = 1'b0;
        if (32'(t) < TYPES && 32'(o) < TYPES && 32'(sel) < FILT_REGS)
        begin
            bit_val = flt[sel][pos];
        end
        return bit_val;
    endfunction

endpackage

// ----- sv/acs_rect_store.sv -----
// Rectangle table memory: one write port, two registered read ports.
// Depends on acs_pkg for the entry type and table depth.
module acs_rect_store
    import acs_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  rect_t             wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr_a,
    input  logic [SLOT_W-1:0] rd_addr_b,
    output rect_t             rd_data_a,
    output rect_t             rd_data_b
);

    rect_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- sv/aabb_pair_collision_scanner.sv -----
// Top level of the rectangle pair collision scanner.
// Depends on acs_pkg and acs_rect_store.
//
// Usage:
//   Input stream (s_axis_*): one command per transfer; tuser selects write, delete
//   or scan. A scan walks every slot pair i<j in slot order and streams collision
//   events on m_axis_*, then one empty result with tlast set (tuser low). Commands
//   are not taken while a scan runs. A pair with an empty slot is skipped; a pair
//   of valid slots is read, tested and its events emitted, and the end marker
//   follows the last pair. The pair loop is set by the table memory: both entries
//   of a pair are read in the same cycle and tested in the next. The first result
//   at the earliest follows the scan transfer through the pair read, the test and
//   the output register.
//   The output register holds one result; a stalled receiver holds the scan in
//   place, nothing is dropped. Further commands are accepted while the final
//   result still waits.
//   Filter registers sit on the APB port at byte addresses 0, 8 and 16.
//   Reset clears all slot valid bits, the filter registers and the scan state;
//   table contents are undefined until written.
module aabb_pair_collision_scanner
    import acs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: slot[2:0], pos_x[18:3], pos_y[34:19], width[49:35], height[64:50],
    //        kind[68:65], has_receiver[69], zero[71:70]
    input  logic [71:0] s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: receiver_slot[2:0], other_slot[5:3], zero[7:6]
    output logic [7:0]  m_axis_tdata,
    // tuser: event_valid
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAIR = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_LAST = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] i_reg, i_next;
    logic [SLOT_W-1:0] j_reg, j_next;
    logic              pend_a_reg, pend_a_next;
    logic              pend_b_reg, pend_b_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    filt_t             filt_reg;

    logic              out_valid_reg;
    logic              out_ev_reg;
    logic              out_last_reg;
    logic [2:0]        out_recv_reg;
    logic [2:0]        out_other_reg;

    logic              put_en;
    logic              put_ev;
    logic              put_last;
    logic [2:0]        put_recv;
    logic [2:0]        put_other;
    logic              can_put;

    logic              in_xfer;
    logic [2:0]        in_slot;
    logic [1:0]        in_func;
    logic              slot_ok;
    rect_t             in_rect;

    logic              rd_en;
    rect_t             rect_a;
    rect_t             rect_b;
    logic              overlap;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FILT_LOW:  filt_reg[0] <= pwdata[FILT_W-1:0];
                REG_FILT_MID:  filt_reg[1] <= pwdata[FILT_W-1:0];
                REG_FILT_HIGH: filt_reg[2] <= pwdata[FILT_W-1:0];
                default:       filt_reg    <= filt_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FILT_LOW:  prdata = 64'(filt_reg[0]);
            REG_FILT_MID:  prdata = 64'(filt_reg[1]);
            REG_FILT_HIGH: prdata = 64'(filt_reg[2]);
            default:       prdata = '0;
        endcase
    end

    // ---------------- command intake ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign in_func       = s_axis_tuser;
    assign in_slot       = s_axis_tdata[2:0];
    assign slot_ok       = (32'(in_slot) < SLOTS);

    assign in_rect.x    = $signed(s_axis_tdata[18:3]);
    assign in_rect.y    = $signed(s_axis_tdata[34:19]);
    assign in_rect.w    = s_axis_tdata[49:35];
    assign in_rect.h    = s_axis_tdata[64:50];
    assign in_rect.kind = s_axis_tdata[68:65];
    assign in_rect.recv = s_axis_tdata[69];

    acs_rect_store u_store (
        .clk       (clk),
        .wr_en     (in_xfer && in_func == FUNC_WRITE && slot_ok),
        .wr_addr   (in_slot[SLOT_W-1:0]),
        .wr_data   (in_rect),
        .rd_en     (rd_en),
        .rd_addr_a (i_reg),
        .rd_addr_b (j_reg),
        .rd_data_a (rect_a),
        .rd_data_b (rect_b)
    );

    // ---------------- strict overlap on 17-bit signed edges ----------------
    always_comb
    begin
        logic signed [16:0] ax, ay, bx, by, ax2, ay2, bx2, by2;
        ax  = 17'(rect_a.x);
        ay  = 17'(rect_a.y);
        bx  = 17'(rect_b.x);
        by  = 17'(rect_b.y);
        ax2 = ax + $signed({2'b00, rect_a.w});
        ay2 = ay + $signed({2'b00, rect_a.h});
        bx2 = bx + $signed({2'b00, rect_b.w});
        by2 = by + $signed({2'b00, rect_b.h});
        overlap = (ax < bx2) && (ax2 > bx) && (ay < by2) && (ay2 > by);
    end

    // ---------------- scan sequencer ----------------
    assign can_put = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        logic adv;
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        valid_next  = valid_reg;
        rd_en       = 1'b0;
        put_en      = 1'b0;
        put_ev      = 1'b0;
        put_last    = 1'b0;
        put_recv    = 3'(i_reg);
        put_other   = 3'(j_reg);
        adv         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_func)
                        FUNC_WRITE:
                        begin
                            if (slot_ok)
                            begin
                                valid_next[in_slot[SLOT_W-1:0]] = 1'b1;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (slot_ok)
                            begin
                                valid_next[in_slot[SLOT_W-1:0]] = 1'b0;
                            end
                        end
                        FUNC_SCAN:
                        begin
                            i_next     = '0;
                            j_next     = SLOT_W'(1);
                            state_next = ST_PAIR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAIR:
            begin
                if (valid_reg[i_reg] && valid_reg[j_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_TEST;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_TEST:
            begin
                pend_a_next = overlap && rect_a.recv &&
                              filter_bit(filt_reg, rect_a.kind, rect_b.kind);
                pend_b_next = overlap && rect_b.recv &&
                              filter_bit(filt_reg, rect_b.kind, rect_a.kind);
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (pend_a_reg)
                begin
                    if (can_put)
                    begin
                        put_en      = 1'b1;
                        put_ev      = 1'b1;
                        pend_a_next = 1'b0;
                    end
                end
                else if (pend_b_reg)
                begin
                    if (can_put)
                    begin
                        put_en      = 1'b1;
                        put_ev      = 1'b1;
                        put_recv    = 3'(j_reg);
                        put_other   = 3'(i_reg);
                        pend_b_next = 1'b0;
                    end
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_LAST:
            begin
                put_recv  = '0;
                put_other = '0;
                if (can_put)
                begin
                    put_en     = 1'b1;
                    put_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next pair i<j, or finish
        if (adv)
        begin
            if (j_reg == SLOT_W'(SLOTS - 1))
            begin
                if (i_reg == SLOT_W'(SLOTS - 2))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + 1'b1 + 1'b1;
                    state_next = ST_PAIR;
                end
            end
            else
            begin
                j_next     = j_reg + 1'b1;
                state_next = ST_PAIR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
            valid_reg  <= valid_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (put_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            out_ev_reg    <= put_ev;
            out_last_reg  <= put_last;
            out_recv_reg  <= put_recv;
            out_other_reg <= put_other;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_other_reg, out_recv_reg};
    assign m_axis_tuser  = out_ev_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- verif/aabb_pair_collision_scanner_tb.sv -----
// Self-checking testbench for aabb_pair_collision_scanner.
// Drives write, delete and scan commands, predicts each scan's collision events
// and checks the result stream. Depends on acs_pkg and the scanner RTL.
module aabb_pair_collision_scanner_tb
    import acs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         RANDOM_SEGMENTS = 6;
    localparam int         SEGMENT_ITEMS = 73;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [3:0]         kind;
        logic               recv;
    } command_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] recv_slot;
        logic [2:0] other_slot;
        logic       last;
    } collision_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: slot, pos_x, pos_y, width, height, kind, has_receiver, zero pad
    logic [71:0] s_axis_tdata = '0;
    // tuser: func
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: receiver_slot, other_slot, zero pad
    logic [7:0]  m_axis_tdata;
    // tuser: event_valid
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    command_t   cmd_q[$];
    collision_t pending_events[$];
    int         issued = 0;
    int         accepted = 0;
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic       cmd_taken = 1'b0;

    // Shadow copy of the scanner's table and filter registers
    command_t          slot_rect [SLOTS];
    logic              slot_live [SLOTS];
    logic [FILT_W-1:0] filter_rows [FILT_REGS];

    aabb_pair_collision_scanner i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void queue_cmd(input int func, input int slot, input int x, input int y,
                                      input int w, input int h, input int kind, input int recv);
        command_t c;
        c.func = 2'(func);
        c.slot = 3'(slot);
        c.x    = 16'(x);
        c.y    = 16'(y);
        c.w    = 15'(w);
        c.h    = 15'(h);
        c.kind = 4'(kind);
        c.recv = 1'(recv);
        cmd_q.push_back(c);
        issued++;
    endfunction

    function automatic logic notify_bit(input logic [3:0] t, input logic [3:0] o);
        int row;
        int col;
        row = int'(t);
        col = int'(o);
        if (row >= TYPES || col >= TYPES)
        begin
            return 1'b0;
        end
        return filter_rows[row / ROWS_PER_REG][(row % ROWS_PER_REG) * ROW_W + col];
    endfunction

    // Strict overlap on sign-extended edges; touching edges do not count
    function automatic logic overlaps(input command_t a, input command_t b);
        int ax;
        int ay;
        int bx;
        int by;
        ax = a.x;
        ay = a.y;
        bx = b.x;
        by = b.y;
        return (ax < bx + int'(b.w)) && (ax + int'(a.w) > bx) &&
               (ay < by + int'(b.h)) && (ay + int'(a.h) > by);
    endfunction

    function automatic void queue_result(input logic hit, input int r, input int o,
                                         input logic last);
        collision_t e;
        e.hit        = hit;
        e.recv_slot  = 3'(r);
        e.other_slot = 3'(o);
        e.last       = last;
        pending_events.push_back(e);
    endfunction

    function automatic void apply_command(input command_t c);
        case (c.func)
            FUNC_WRITE:
            begin
                slot_rect[c.slot] = c;
                slot_live[c.slot] = 1'b1;
            end
            FUNC_DELETE:
            begin
                slot_live[c.slot] = 1'b0;
            end
            FUNC_SCAN:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    for (int j = i + 1; j < SLOTS; j++)
                    begin
                        if (slot_live[i] && slot_live[j] && overlaps(slot_rect[i], slot_rect[j]))
                        begin
                            if (slot_rect[i].recv && notify_bit(slot_rect[i].kind, slot_rect[j].kind))
                            begin
                                queue_result(1'b1, i, j, 1'b0);
                            end
                            if (slot_rect[j].recv && notify_bit(slot_rect[j].kind, slot_rect[i].kind))
                            begin
                                queue_result(1'b1, j, i, 1'b0);
                            end
                        end
                    end
                end
                queue_result(1'b0, 0, 0, 1'b1);
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
    endfunction

    task automatic write_filter(input logic [1:0] idx, input logic [FILT_W-1:0] value);
        logic [63:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= 64'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        filter_rows[idx] = value;
        // read back straight after the write
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != 64'(value))
        begin
            flag_error($sformatf("filter register %0d reads %h, wrote %h", idx, readback, value));
        end
    endtask

    task automatic set_filters(input logic [FILT_W-1:0] low_rows, input logic [FILT_W-1:0] mid_rows,
                               input logic [FILT_W-1:0] high_rows);
        write_filter(REG_FILT_LOW, low_rows);
        write_filter(REG_FILT_MID, mid_rows);
        write_filter(REG_FILT_HIGH, high_rows);
    endtask

    // Hold until every command is in and every result is out, then let the block settle
    task automatic drain();
        while (accepted != issued) @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive_commands
        command_t nxt;
        if (rst_n && (!s_axis_tvalid || cmd_taken))
        begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.func;
                s_axis_tdata  <= {2'b00, nxt.recv, nxt.kind, nxt.h, nxt.w, nxt.y, nxt.x, nxt.slot};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch_streams
        command_t   cmd;
        collision_t got;
        collision_t want;
        cmd_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            cmd.func = s_axis_tuser;
            cmd.slot = s_axis_tdata[2:0];
            cmd.x    = s_axis_tdata[18:3];
            cmd.y    = s_axis_tdata[34:19];
            cmd.w    = s_axis_tdata[49:35];
            cmd.h    = s_axis_tdata[64:50];
            cmd.kind = s_axis_tdata[68:65];
            cmd.recv = s_axis_tdata[69];
            apply_command(cmd);
            accepted <= accepted + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hit        = m_axis_tuser;
            got.recv_slot  = m_axis_tdata[2:0];
            got.other_slot = m_axis_tdata[5:3];
            got.last       = m_axis_tlast;
            if (pending_events.size() == 0)
            begin
                flag_error($sformatf("unexpected result hit=%b recv=%0d other=%0d last=%b",
                                     got.hit, got.recv_slot, got.other_slot, got.last));
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.hit !== want.hit || got.recv_slot !== want.recv_slot ||
                    got.other_slot !== want.other_slot || got.last !== want.last)
                begin
                    flag_error($sformatf("result hit=%b recv=%0d other=%0d last=%b, expected %b %0d %0d %b",
                                         got.hit, got.recv_slot, got.other_slot, got.last,
                                         want.hit, want.recv_slot, want.other_slot, want.last));
                end
            end
        end
    end

    initial
    begin
        int pick;
        int x;
        int y;
        int w;
        int h;
        int kind;
        logic wide;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_live[s] = 1'b0;
            slot_rect[s] = '0;
        end
        for (int r = 0; r < FILT_REGS; r++)
        begin
            filter_rows[r] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 80;
        set_filters('1, '1, '1);

        // corners of the coordinate range, touching edges, zero sizes, kinds past the filter
        queue_cmd(FUNC_WRITE, 0, -32768, -32768, 32767, 32767, 0, 1);
        queue_cmd(FUNC_WRITE, 1, 32767, 32767, 0, 0, 11, 1);
        queue_cmd(FUNC_WRITE, 2, -100, -100, 200, 200, 3, 1);
        queue_cmd(FUNC_WRITE, 3, 0, 0, 10, 10, 15, 1);
        queue_cmd(FUNC_WRITE, 4, 100, -100, 50, 50, 5, 0);
        queue_cmd(FUNC_WRITE, 5, -5, -5, 20, 20, 12, 1);
        queue_cmd(FUNC_WRITE, 6, 0, 0, 0, 0, 7, 1);
        queue_cmd(FUNC_WRITE, 7, -32768, 0, 32767, 1, 10, 0);
        queue_cmd(FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(FUNC_UNUSED, 7, -1, -1, 32767, 32767, 15, 1);
        queue_cmd(FUNC_DELETE, 2, 0, 0, 0, 0, 0, 0);
        queue_cmd(FUNC_DELETE, 2, 0, 0, 0, 0, 0, 0);
        queue_cmd(FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(FUNC_WRITE, 2, -1, -1, 32767, 32767, 15, 1);
        queue_cmd(FUNC_SCAN, 5, 0, 0, 0, 0, 0, 0);
        for (int s = 0; s < SLOTS; s++)
        begin
            queue_cmd(FUNC_DELETE, s, 0, 0, 0, 0, 0, 0);
        end
        queue_cmd(FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0);
        drain();

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 80 : 0;
            recv_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 9 : 0;
            case (seg)
                1: set_filters('0, '0, '0);
                3: set_filters('1, '0, FILT_W'({$urandom(), $urandom()}));
                5: set_filters('1, '1, '1);
                default: set_filters(FILT_W'({$urandom(), $urandom()}),
                                     FILT_W'({$urandom(), $urandom()}),
                                     FILT_W'({$urandom(), $urandom()}));
            endcase
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                // most rectangles crowd round the origin so that scans find pairs
                wide = ($urandom_range(0, 99) < 25);
                x    = wide ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 240)) - 120;
                y    = wide ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 240)) - 120;
                w    = wide ? int'($urandom_range(0, 32767)) : int'($urandom_range(0, 120));
                h    = wide ? int'($urandom_range(0, 32767)) : int'($urandom_range(0, 120));
                kind = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, TYPES - 1))
                                                    : int'($urandom_range(TYPES, 15));
                if (pick < 55)
                begin
                    queue_cmd(FUNC_WRITE, $urandom_range(0, 7), x, y, w, h, kind,
                              ($urandom_range(0, 99) < 75) ? 1 : 0);
                end
                else
                begin
                    queue_cmd((pick < 70) ? FUNC_DELETE : (pick < 94) ? FUNC_SCAN : FUNC_UNUSED,
                              $urandom_range(0, 7), int'($urandom_range(0, 65535)),
                              int'($urandom_range(0, 65535)), int'($urandom_range(0, 32767)),
                              int'($urandom_range(0, 32767)), int'($urandom_range(0, 15)),
                              $urandom_range(0, 1));
                end
            end
            queue_cmd(FUNC_SCAN, 0, 0, 0, 0, 0, 0, 0);
            drain();
        end

        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
